// File: src/mglpb_pkg.sv
package mglpb_pkg;

   localparam int DEF_CAPACITY       = 64;
   localparam int DEF_ADDR_WIDTH     = 32;
   localparam int DEF_SUPERPAGE_BITS = 22;
   localparam int DEF_PAGE_BITS      = 12;
   localparam int DEF_LINE_BITS      = 6;

   localparam int TAG_W   = 32;
   localparam int LEVEL_W = 2;
   localparam int OCC_W   = 7;
   localparam int GROUP_N = 8;

   localparam logic [LEVEL_W-1:0] LVL_ALL   = 2'd0;
   localparam logic [LEVEL_W-1:0] LVL_SUPER = 2'd1;
   localparam logic [LEVEL_W-1:0] LVL_PAGE  = 2'd2;
   localparam logic [LEVEL_W-1:0] LVL_LINE  = 2'd3;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_SHOOT  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP,
      ST_UPD,
      ST_CNT,
      ST_SUM
   } state_type;

   typedef struct packed {
      logic cmp_en;
      logic upd_en;
      logic shoot;
      logic hit;
      logic push;
   } cell_ctrl_type;

endpackage

// File: src/mglpb_span.sv
module mglpb_span
   import mglpb_pkg::*;
#(
   parameter int ADDR_WIDTH     = DEF_ADDR_WIDTH,
   parameter int SUPERPAGE_BITS = DEF_SUPERPAGE_BITS,
   parameter int PAGE_BITS      = DEF_PAGE_BITS,
   parameter int LINE_BITS      = DEF_LINE_BITS
) (
   input  logic [ADDR_WIDTH-1:0] tag,
   input  logic [LEVEL_W-1:0]    level,
   output logic [ADDR_WIDTH-1:0] span_lo,
   output logic [ADDR_WIDTH-1:0] span_hi
);

   logic [ADDR_WIDTH-1:0] next_tag;
   logic [ADDR_WIDTH-1:0] next_lo;

   assign next_tag = tag + ADDR_WIDTH'(1);

   always_comb begin
      unique case (level)
         LVL_SUPER: begin
            span_lo = tag << SUPERPAGE_BITS;
            next_lo = next_tag << SUPERPAGE_BITS;
         end
         LVL_PAGE: begin
            span_lo = tag << PAGE_BITS;
            next_lo = next_tag << PAGE_BITS;
         end
         default: begin
            span_lo = tag << LINE_BITS;
            next_lo = next_tag << LINE_BITS;
         end
      endcase
   end

   assign span_hi = next_lo - ADDR_WIDTH'(1);

endmodule

// File: src/mglpb_cell.sv
module mglpb_cell
   import mglpb_pkg::*;
#(
   parameter int ADDR_WIDTH     = DEF_ADDR_WIDTH,
   parameter int SUPERPAGE_BITS = DEF_SUPERPAGE_BITS,
   parameter int PAGE_BITS      = DEF_PAGE_BITS,
   parameter int LINE_BITS      = DEF_LINE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctrl_type         ctrl,
   input  logic [ADDR_WIDTH-1:0] req_tag,
   input  logic [LEVEL_W-1:0]    req_level,
   input  logic [ADDR_WIDTH-1:0] req_lo,
   input  logic [ADDR_WIDTH-1:0] req_hi,
   input  logic                  left_valid,
   input  logic [ADDR_WIDTH-1:0] left_tag,
   input  logic [LEVEL_W-1:0]    left_level,
   input  logic                  hole_in,
   output logic                  hole_out,
   output logic                  valid,
   output logic [ADDR_WIDTH-1:0] tag,
   output logic [LEVEL_W-1:0]    level,
   output logic                  match
);

   logic                  valid_ff, valid_in;
   logic [ADDR_WIDTH-1:0] tag_ff, tag_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic                  match_ff, match_in;
   logic                  ovl_ff, ovl_in;
   logic [ADDR_WIDTH-1:0] span_lo;
   logic [ADDR_WIDTH-1:0] span_hi;
   logic                  kill;
   logic                  shift;

   mglpb_span #(
      .ADDR_WIDTH    (ADDR_WIDTH),
      .SUPERPAGE_BITS(SUPERPAGE_BITS),
      .PAGE_BITS     (PAGE_BITS),
      .LINE_BITS     (LINE_BITS)
   ) u_span (
      .tag    (tag_ff),
      .level  (level_ff),
      .span_lo(span_lo),
      .span_hi(span_hi)
   );

   assign kill     = valid_ff && (ctrl.shoot ? ovl_ff : (ctrl.hit ? match_ff : ovl_ff));
   assign hole_out = hole_in || !valid_ff || kill;
   assign shift    = ctrl.push && !hole_in;

   always_comb begin
      match_in = match_ff;
      ovl_in   = ovl_ff;
      valid_in = valid_ff;
      tag_in   = tag_ff;
      level_in = level_ff;
      if (ctrl.cmp_en) begin
         match_in = valid_ff && (tag_ff == req_tag) && (level_ff == req_level);
         ovl_in   = valid_ff && ((level_ff == LVL_ALL) ||
                                 ((req_hi >= span_lo) && (req_lo <= span_hi)));
      end
      if (ctrl.upd_en) begin
         if (shift) begin
            valid_in = left_valid;
            tag_in   = left_tag;
            level_in = left_level;
         end else if (kill) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      tag_ff   <= tag_in;
      level_ff <= level_in;
      match_ff <= match_in;
      ovl_ff   <= ovl_in;
   end

   assign valid = valid_ff;
   assign tag   = tag_ff;
   assign level = level_ff;
   assign match = match_ff;

endmodule

// File: src/multi_granule_lru_protection_buffer_top.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   cmd, level, tag, first_addr, last_addr
// rsp       out        rsp_valid/rsp_ready   hit, occupancy
//
// Each item passes through capture, compare in every cell, update of the cell chain,
// and the occupancy count: sums over groups of eight cells are registered, then added.
// A new item is taken only once the previous one has left the count stage.
// A finished result waits in the output register, and the block accepts the next
// item meanwhile; a stalled result holds the count stage. Reset empties the buffer.
module multi_granule_lru_protection_buffer_top
   import mglpb_pkg::*;
#(
   parameter int CAPACITY       = DEF_CAPACITY,
   parameter int ADDR_WIDTH     = DEF_ADDR_WIDTH,
   parameter int SUPERPAGE_BITS = DEF_SUPERPAGE_BITS,
   parameter int PAGE_BITS      = DEF_PAGE_BITS,
   parameter int LINE_BITS      = DEF_LINE_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic [LEVEL_W-1:0] req_level,
   input  logic [TAG_W-1:0]   req_tag,
   input  logic [TAG_W-1:0]   req_first_addr,
   input  logic [TAG_W-1:0]   req_last_addr,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic [OCC_W-1:0]   rsp_occupancy
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int GROUPS = (CAPACITY + GROUP_N - 1) / GROUP_N;
   localparam int GSUM_W = $clog2(GROUP_N + 1);

   state_type state_ff, state_in;
   cell_ctrl_type ctrl;

   logic                  cmd_ff, cmd_in;
   logic [ADDR_WIDTH-1:0] rtag_ff, rtag_in;
   logic [LEVEL_W-1:0]    rlvl_ff, rlvl_in;
   logic [ADDR_WIDTH-1:0] rlo_ff, rlo_in;
   logic [ADDR_WIDTH-1:0] rhi_ff, rhi_in;
   logic                  hit_ff, hit_in;
   logic [GSUM_W-1:0]     gsum_ff [GROUPS];
   logic [GSUM_W-1:0]     gsum_in [GROUPS];
   logic [CNT_W-1:0]      count_sum;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [OCC_W-1:0]      rsp_occ_ff, rsp_occ_in;

   logic [ADDR_WIDTH-1:0] in_tag;
   logic [ADDR_WIDTH-1:0] in_lo;
   logic [ADDR_WIDTH-1:0] in_hi;
   logic                  accept;
   logic                  load_rsp;
   logic                  any_match;

   logic                  valid_chain [CAPACITY+1];
   logic [ADDR_WIDTH-1:0] tag_chain   [CAPACITY+1];
   logic [LEVEL_W-1:0]    level_chain [CAPACITY+1];
   logic                  hole_chain  [CAPACITY+1];
   logic [CAPACITY-1:0]   match_vec;
   logic [CAPACITY-1:0]   valid_vec;

   assign in_tag = ADDR_WIDTH'(req_tag);

   mglpb_span #(
      .ADDR_WIDTH    (ADDR_WIDTH),
      .SUPERPAGE_BITS(SUPERPAGE_BITS),
      .PAGE_BITS     (PAGE_BITS),
      .LINE_BITS     (LINE_BITS)
   ) u_span (
      .tag    (in_tag),
      .level  (req_level),
      .span_lo(in_lo),
      .span_hi(in_hi)
   );

   assign valid_chain[0] = 1'b1;
   assign tag_chain[0]   = rtag_ff;
   assign level_chain[0] = rlvl_ff;
   assign hole_chain[0]  = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      mglpb_cell #(
         .ADDR_WIDTH    (ADDR_WIDTH),
         .SUPERPAGE_BITS(SUPERPAGE_BITS),
         .PAGE_BITS     (PAGE_BITS),
         .LINE_BITS     (LINE_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .req_tag   (rtag_ff),
         .req_level (rlvl_ff),
         .req_lo    (rlo_ff),
         .req_hi    (rhi_ff),
         .left_valid(valid_chain[i]),
         .left_tag  (tag_chain[i]),
         .left_level(level_chain[i]),
         .hole_in   (hole_chain[i]),
         .hole_out  (hole_chain[i+1]),
         .valid     (valid_chain[i+1]),
         .tag       (tag_chain[i+1]),
         .level     (level_chain[i+1]),
         .match     (match_vec[i])
      );
      assign valid_vec[i] = valid_chain[i+1];
   end

   assign any_match = |match_vec;
   assign accept    = req_valid && req_ready;
   assign load_rsp  = (state_ff == ST_SUM) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_CMP;
         ST_CMP:  state_in = ST_UPD;
         ST_UPD:  state_in = ST_CNT;
         ST_CNT:  state_in = ST_SUM;
         ST_SUM:  if (load_rsp) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      ctrl        = '0;
      ctrl.shoot  = (cmd_ff == CMD_SHOOT);
      ctrl.hit    = (cmd_ff == CMD_LOOKUP) && any_match;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_CMP:  ctrl.cmp_en = 1'b1;
         ST_UPD: begin
            ctrl.upd_en = 1'b1;
            ctrl.push   = (cmd_ff == CMD_LOOKUP);
         end
         default: ;
      endcase
   end

   always_comb begin
      cmd_in  = cmd_ff;
      rtag_in = rtag_ff;
      rlvl_in = rlvl_ff;
      rlo_in  = rlo_ff;
      rhi_in  = rhi_ff;
      if (accept) begin
         cmd_in  = req_cmd;
         rtag_in = in_tag;
         rlvl_in = req_level;
         if (req_cmd == CMD_SHOOT) begin
            rlo_in = ADDR_WIDTH'(req_first_addr);
            rhi_in = ADDR_WIDTH'(req_last_addr);
         end else if (req_level == LVL_ALL) begin
            rlo_in = '0;
            rhi_in = '1;
         end else begin
            rlo_in = in_lo;
            rhi_in = in_hi;
         end
      end
   end

   assign hit_in = (state_ff == ST_UPD) ? ctrl.hit : hit_ff;

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         gsum_in[g] = '0;
         for (int k = 0; k < GROUP_N; k++) begin
            if (g * GROUP_N + k < CAPACITY) begin
               gsum_in[g] = gsum_in[g] + GSUM_W'(valid_vec[g * GROUP_N + k]);
            end
         end
      end
   end

   always_comb begin
      count_sum = '0;
      for (int g = 0; g < GROUPS; g++) begin
         count_sum = count_sum + CNT_W'(gsum_ff[g]);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_occ_in   = rsp_occ_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit_ff;
         rsp_occ_in   = OCC_W'(count_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff     <= cmd_in;
      rtag_ff    <= rtag_in;
      rlvl_ff    <= rlvl_in;
      rlo_ff     <= rlo_in;
      rhi_ff     <= rhi_in;
      hit_ff     <= hit_in;
      gsum_ff    <= gsum_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_occ_ff <= rsp_occ_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule
